[hw/rtl/base64url_stream_encoder_core_macros.svh]
// Assertion helpers used by the b64u_chk checker.
`ifndef BASE64URL_STREAM_ENCODER_CORE_MACROS_SVH
`define BASE64URL_STREAM_ENCODER_CORE_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define B64U_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define B64U_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/b64u_pkg.sv]
package b64u_pkg;

    localparam int unsigned CHAR_W = 7;

    // Leftover phase: number of pending bits is 0, 2 or 4.
    localparam logic [1:0] PH_0 = 2'd0;
    localparam logic [1:0] PH_2 = 2'd1;
    localparam logic [1:0] PH_4 = 2'd2;

    localparam logic [CHAR_W-1:0] ASC_UPPER_A = 7'd65;
    localparam logic [CHAR_W-1:0] ASC_LOWER_A = 7'd97;
    localparam logic [CHAR_W-1:0] ASC_DIGIT_0 = 7'd48;
    localparam logic [CHAR_W-1:0] ASC_MINUS   = 7'd45;
    localparam logic [CHAR_W-1:0] ASC_USCORE  = 7'd95;

    localparam logic [5:0] SEX_LOWER = 6'd26;
    localparam logic [5:0] SEX_DIGIT = 6'd52;
    localparam logic [5:0] SEX_MINUS = 6'd62;

    typedef struct packed {
        logic [CHAR_W-1:0] chr;
        logic              run_last;
        logic              text_end;
    } t_res;

    typedef struct packed {
        logic two;
        t_res r0;
        t_res r1;
    } t_split;

    function automatic logic [CHAR_W-1:0] enc_char(input logic [5:0] s);
        logic [CHAR_W-1:0] v;
        v = {1'b0, s};
        if (s < SEX_LOWER) begin
            enc_char = ASC_UPPER_A + v;
        end else if (s < SEX_DIGIT) begin
            enc_char = ASC_LOWER_A + v - {1'b0, SEX_LOWER};
        end else if (s < SEX_MINUS) begin
            enc_char = ASC_DIGIT_0 + v - {1'b0, SEX_DIGIT};
        end else if (s == SEX_MINUS) begin
            enc_char = ASC_MINUS;
        end else begin
            enc_char = ASC_USCORE;
        end
    endfunction

endpackage

[hw/rtl/b64u_split.sv]
module b64u_split (
    input  logic [7:0]          i_byte,
    input  logic                i_last,
    input  logic [3:0]          i_pend,
    input  logic [1:0]          i_phase,
    output b64u_pkg::t_split    o_split,
    output logic [3:0]          o_pend,
    output logic [1:0]          o_phase
);

    logic [5:0] s0;
    logic [5:0] s1;
    logic       two;

    always_comb begin
        unique case (i_phase)
            b64u_pkg::PH_0: begin
                s0      = i_byte[7:2];
                s1      = {i_byte[1:0], 4'b0000};
                two     = i_last;
                o_pend  = i_last ? 4'd0 : {2'b00, i_byte[1:0]};
                o_phase = i_last ? b64u_pkg::PH_0 : b64u_pkg::PH_2;
            end
            b64u_pkg::PH_2: begin
                s0      = {i_pend[1:0], i_byte[7:4]};
                s1      = {i_byte[3:0], 2'b00};
                two     = i_last;
                o_pend  = i_last ? 4'd0 : i_byte[3:0];
                o_phase = i_last ? b64u_pkg::PH_0 : b64u_pkg::PH_4;
            end
            default: begin
                // four pending bits; unused code clamps here
                s0      = {i_pend[3:0], i_byte[7:6]};
                s1      = i_byte[5:0];
                two     = 1'b1;
                o_pend  = 4'd0;
                o_phase = b64u_pkg::PH_0;
            end
        endcase

        o_split.two         = two;
        o_split.r0.chr      = b64u_pkg::enc_char(s0);
        o_split.r0.run_last = ~two;
        o_split.r0.text_end = i_last & ~two;
        o_split.r1.chr      = b64u_pkg::enc_char(s1);
        o_split.r1.run_last = 1'b1;
        o_split.r1.text_end = i_last;
    end

endmodule

[hw/rtl/base64url_stream_encoder_core.sv]
// Base64url encoder without '=' padding. Each input transaction carries one
// raw byte (tlast marks the last byte of a text) and yields one or two output
// transactions, each one URL-safe base64 character in o_m_tdata[6:0]; o_m_tlast
// marks the last character caused by a byte and o_m_tuser[0] the last character
// of the text. A new byte is accepted when no character waits in r_a0/r_a1,
// or as the last waiting one moves to the output register r_o. The output
// gives one character per cycle while i_m_tready is high. Leftover bits are
// flushed on the last byte.
module base64url_stream_encoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] data_byte
    input  logic       i_s_tlast,   // final_byte
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,   // [6:0] out_char, [7] zero
    output logic       o_m_tlast,   // run_last
    output logic [0:0] o_m_tuser    // [0] text_end
);

    logic [3:0]       r_pend;
    logic [3:0]       n_pend;
    logic [1:0]       r_phase;
    logic [1:0]       n_phase;
    logic [1:0]       r_a_cnt;
    logic [1:0]       n_a_cnt;
    b64u_pkg::t_res   r_a0;
    b64u_pkg::t_res   n_a0;
    b64u_pkg::t_res   r_a1;
    b64u_pkg::t_res   n_a1;
    logic             r_o_vld;
    logic             n_o_vld;
    b64u_pkg::t_res   r_o;
    b64u_pkg::t_res   n_o;

    b64u_pkg::t_split sp;
    logic [3:0]       sp_pend;
    logic [1:0]       sp_phase;
    logic             move;
    logic             in_acc;

    b64u_split u_split (
        .i_byte  (i_s_tdata),
        .i_last  (i_s_tlast),
        .i_pend  (r_pend),
        .i_phase (r_phase),
        .o_split (sp),
        .o_pend  (sp_pend),
        .o_phase (sp_phase)
    );

    assign move       = (r_a_cnt != 2'd0) && (!r_o_vld || i_m_tready);
    assign o_s_tready = (r_a_cnt == 2'd0) || ((r_a_cnt == 2'd1) && move);
    assign in_acc     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_pend  = r_pend;
        n_phase = r_phase;
        n_a_cnt = r_a_cnt;
        n_a0    = r_a0;
        n_a1    = r_a1;
        n_o_vld = r_o_vld;
        n_o     = r_o;

        if (move) begin
            n_o     = r_a0;
            n_o_vld = 1'b1;
            n_a0    = r_a1;
            n_a_cnt = r_a_cnt - 2'd1;
        end else if (i_m_tready) begin
            n_o_vld = 1'b0;
        end

        if (in_acc) begin
            n_a0    = sp.r0;
            n_a1    = sp.r1;
            n_a_cnt = sp.two ? 2'd2 : 2'd1;
            n_pend  = sp_pend;
            n_phase = sp_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend  <= 4'd0;
            r_phase <= b64u_pkg::PH_0;
            r_a_cnt <= 2'd0;
            r_o_vld <= 1'b0;
        end else begin
            r_pend  <= n_pend;
            r_phase <= n_phase;
            r_a_cnt <= n_a_cnt;
            r_o_vld <= n_o_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a0 <= n_a0;
        r_a1 <= n_a1;
        r_o  <= n_o;
    end

    assign o_m_tvalid = r_o_vld;
    assign o_m_tdata  = {1'b0, r_o.chr};
    assign o_m_tlast  = r_o.run_last;
    assign o_m_tuser  = r_o.text_end;

endmodule

[hw/rtl/b64u_chk.sv]
`include "base64url_stream_encoder_core_macros.svh"

module b64u_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast,
    input logic [0:0] o_m_tuser
);

    logic       ch_ok;
    logic [9:0] m_bus;

    assign ch_ok = (o_m_tdata >= 8'd65 && o_m_tdata <= 8'd90)
                || (o_m_tdata >= 8'd97 && o_m_tdata <= 8'd122)
                || (o_m_tdata >= 8'd48 && o_m_tdata <= 8'd57)
                || o_m_tdata == 8'd45 || o_m_tdata == 8'd95;
    assign m_bus = {o_m_tuser, o_m_tlast, o_m_tdata};

    // character must be from the URL-safe alphabet
    `B64U_ASSERT_NOW(a_alphabet, i_clk, i_rst_n, o_m_tvalid, ch_ok, "char outside alphabet")

    // end of text is always the end of a byte's run
    `B64U_ASSERT_NOW(a_end_in_run, i_clk, i_rst_n, o_m_tvalid && o_m_tuser[0], o_m_tlast, "text end without run end")

    // second character of a byte follows right after the first
    `B64U_ASSERT_NEXT(a_run_cont, i_clk, i_rst_n, o_m_tvalid && i_m_tready && !o_m_tlast, o_m_tvalid, "run broken")

    // stalled transaction holds
    `B64U_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(m_bus), "stalled output changed")

endmodule

bind base64url_stream_encoder_core b64u_chk u_b64u_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

[sim/testbench.sv]
module testbench;

    class char_checker;
        b64u_pkg::t_res expected_chars[$];
        logic [3:0]     carry_bits;
        logic [2:0]     carry_cnt;
        string          alphabet;
        int             errors;
        int             bytes_seen;
        int             texts_seen;
        int             chars_seen;

        function new();
            alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";
            carry_bits = '0;
            carry_cnt = '0;
            errors = 0;
            bytes_seen = 0;
            texts_seen = 0;
            chars_seen = 0;
        endfunction

        function b64u_pkg::t_res to_char(input logic [5:0] sextet);
            b64u_pkg::t_res r;
            byte            c;
            c = alphabet.getc(sextet);
            r.chr = c[6:0];
            r.run_last = 1'b0;
            r.text_end = 1'b0;
            return r;
        endfunction

        // Input transaction accepted: work out the one or two characters it causes.
        function void note_byte(input logic [7:0] data, input logic fin);
            logic [11:0]    acc;
            int             cnt;
            int             avail;
            int             n;
            b64u_pkg::t_res res [2];
            cnt = carry_cnt;
            if (cnt > 4) cnt = 4;
            acc = ((12'(carry_bits) & ((12'd1 << cnt) - 12'd1)) << 8) | 12'(data);
            avail = cnt + 8;
            n = 0;
            while (avail >= 6) begin
                avail -= 6;
                res[n] = to_char(6'(acc >> avail));
                n++;
            end
            acc &= (12'd1 << avail) - 12'd1;
            if (fin) begin
                if (avail > 0) begin
                    res[n] = to_char(6'(acc << (6 - avail)));
                    n++;
                end
                res[n-1].text_end = 1'b1;
                carry_bits = '0;
                carry_cnt = '0;
                texts_seen++;
            end else begin
                carry_bits = acc[3:0];
                carry_cnt = 3'(avail);
            end
            res[n-1].run_last = 1'b1;
            for (int i = 0; i < n; i++) expected_chars.insert(expected_chars.size(), res[i]);
            bytes_seen++;
        endfunction

        // Output transaction accepted: compare with the oldest expected character.
        function void check_char(input logic [7:0] tdata, input logic tlast,
                                 input logic tuser);
            b64u_pkg::t_res e;
            chars_seen++;
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected character tdata=%h tlast=%b tuser=%b",
                         $time, tdata, tlast, tuser);
                errors++;
                return;
            end
            e = expected_chars.pop_front();
            if (tdata !== {1'b0, e.chr}) begin
                $display("%0t: tdata expected %h actual %h", $time, {1'b0, e.chr}, tdata);
                errors++;
            end
            if (tlast !== e.run_last) begin
                $display("%0t: tlast expected %b actual %b", $time, e.run_last, tlast);
                errors++;
            end
            if (tuser !== e.text_end) begin
                $display("%0t: tuser expected %b actual %b", $time, e.text_end, tuser);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata = 8'd0;   // [7:0] data_byte
    logic       i_s_tlast = 1'b0;   // final_byte
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;          // [6:0] out_char, [7] zero
    logic       o_m_tlast;          // run_last
    logic [0:0] o_m_tuser;          // [0] text_end

    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    char_checker chk = new();

    base64url_stream_encoder_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) chk.note_byte(i_s_tdata, i_s_tlast);
            if (o_m_tvalid && i_m_tready) chk.check_char(o_m_tdata, o_m_tlast, o_m_tuser[0]);
        end
    end

    // Called at a falling edge, returns at a falling edge.
    task automatic send_byte(input logic [7:0] data, input logic fin);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= data;
        i_s_tlast <= fin;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic send_text(input int len);
        for (int i = 0; i < len; i++) send_byte(8'($urandom), i == len - 1);
    endtask

    task automatic drain(input int max_cycles);
        int waited;
        waited = 0;
        i_s_tvalid <= 1'b0;
        while (chk.expected_chars.size() != 0 && waited < max_cycles) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (8) @(negedge i_clk);
    endtask

    // {final_byte, data_byte}: one-byte texts, full groups without pad, all-ones,
    // all-zeros, sextet 62 runs, and texts ending on each leftover count.
    localparam logic [8:0] DIRECTED [25] = '{
        {1'b1, 8'h00},
        {1'b1, 8'hff},
        {1'b0, 8'hff}, {1'b1, 8'hff},
        {1'b0, 8'hff}, {1'b0, 8'hff}, {1'b1, 8'hff},
        {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b1, 8'h00},
        {1'b0, 8'hfb}, {1'b0, 8'hef}, {1'b1, 8'hbe},
        {1'b0, 8'h4d}, {1'b0, 8'h61}, {1'b1, 8'h6e},
        {1'b0, 8'h80}, {1'b0, 8'h01}, {1'b0, 8'h7f}, {1'b1, 8'hfe},
        {1'b0, 8'h55}, {1'b0, 8'haa}, {1'b0, 8'h55}, {1'b0, 8'haa}, {1'b1, 8'h55}
    };

    initial begin
        int phase_start;
        int len;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int i = 0; i < 25; i++) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
        drain(5000);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            phase_start = chk.bytes_seen;
            while (chk.bytes_seen - phase_start < 400) begin
                if ($urandom_range(0, 9) == 0) len = $urandom_range(9, 48);
                else len = $urandom_range(1, 8);
                send_text(len);
            end
            drain(5000);
        end

        if (chk.expected_chars.size() != 0) begin
            $display("%0t: %0d expected characters never arrived",
                     $time, chk.expected_chars.size());
            chk.errors++;
        end
        $display("Encoded %0d bytes in %0d texts into %0d characters,",
                 chk.bytes_seen, chk.texts_seen, chk.chars_seen);
        $display("over four sender/receiver idling mixes; %0d mismatches.", chk.errors);
        if (chk.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #4000000;
        $display("TEST FAILED");
        $finish;
    end
endmodule
